[rtl/i2cbs_pkg.sv]
// ---------------------------------------------------------------------------
// i2cbs_pkg
// Types and codes for the I2C master bit sequencer.
// ---------------------------------------------------------------------------
package i2cbs_pkg;

    localparam int unsigned ACTION_W = 3;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned BIT_W    = 3;
    localparam int unsigned IN_W     = 16;
    localparam int unsigned OUT_W    = 16;

    localparam logic [BIT_W-1:0] BIT_MSB = 3'd7;
    localparam logic [BIT_W-1:0] BIT_LSB = 3'd0;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_WRITE = 3'd3,
        ACT_READ  = 3'd4,
        ACT_ACK   = 3'd5,
        ACT_RSV6  = 3'd6,
        ACT_RSV7  = 3'd7
    } t_action;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_STOP  = 6'b000100,
        ST_WRITE = 6'b001000,
        ST_READ  = 6'b010000,
        ST_ACK   = 6'b100000
    } t_cmd_state;

    localparam logic [PHASE_W-1:0] PH_0 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_1 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_2 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_3 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_4 = 3'd4;

    // one result beat, lowest field last in the packed order
    typedef struct packed {
        logic              ack_seen;
        logic [BYTE_W-1:0] read_byte;
        logic              done_res;
        logic              busy_res;
        logic              sda_level;
        logic              scl_level;
    } t_result;

    localparam int unsigned RES_W = $bits(t_result);

endpackage

[rtl/i2c_master_bit_sequencer.sv]
// ---------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master that steps SCL/SDA one bus phase per input beat.
// ---------------------------------------------------------------------------
// channel   dir  tdata (low bit up)                              tuser
// s_axis    in   write_byte[7:0] ack_to_send[8] sda_sample[9]    action[2:0]
// m_axis    out  scl[0] sda[1] busy[2] done[3] read_byte[11:4]   -
//                ack_seen[12]
//
// every input beat is one bus delay tick and gives exactly one result beat
// one beat is taken per cycle while s_axis is ready; the bus state update and the
// result are computed in the cycle of acceptance and land in the result register,
// or in the skid register behind it when a result waits; the skid register keeps
// s_axis ready while one result waits; s_axis stalls only when both are full
// reset (synchronous, active low) idles the sequencer with both lines released
// ---------------------------------------------------------------------------
module i2c_master_bit_sequencer
    import i2cbs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // write_byte, ack_to_send, sda_sample
    input  logic [2:0]       i_s_axis_tuser,   // action
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata    // scl, sda, busy, done, read_byte, ack_seen
);

    t_cmd_state          r_cmd, n_cmd;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [BIT_W-1:0]    r_bit_idx, n_bit_idx;
    logic [BYTE_W-1:0]   r_shift_out, n_shift_out;
    logic [BYTE_W-1:0]   r_shift_in, n_shift_in;
    logic                r_ack_latch, n_ack_latch;
    logic                r_scl, n_scl;
    logic                r_sda, n_sda;

    logic                r_out_valid, r_skd_valid;
    t_result             r_out, r_skd;

    t_action             in_action;
    logic [BYTE_W-1:0]   in_wbyte;
    logic                in_ack_bit;
    logic                in_sample;
    logic                acc, pop;

    t_cmd_state          eff_cmd;
    logic                scl_now, sda_now, finish;
    t_result             res;

    assign in_action  = t_action'(i_s_axis_tuser);
    assign in_wbyte   = i_s_axis_tdata[BYTE_W-1:0];
    assign in_ack_bit = i_s_axis_tdata[BYTE_W];
    assign in_sample  = i_s_axis_tdata[BYTE_W+1];

    assign o_s_axis_tready = !r_skd_valid;
    assign acc = i_s_axis_tvalid && o_s_axis_tready;
    assign pop = r_out_valid && i_m_axis_tready;

    always_comb begin
        eff_cmd     = r_cmd;
        n_phase     = r_phase;
        n_bit_idx   = r_bit_idx;
        n_shift_out = r_shift_out;
        n_shift_in  = r_shift_in;
        n_ack_latch = r_ack_latch;
        n_scl       = r_scl;
        n_sda       = r_sda;
        finish      = 1'b0;

        // command load, only while idle
        if (r_cmd == ST_IDLE) begin
            n_phase   = PH_0;
            n_bit_idx = BIT_MSB;
            unique case (in_action)
                ACT_START: eff_cmd = ST_START;
                ACT_STOP:  eff_cmd = ST_STOP;
                ACT_WRITE: begin
                    eff_cmd     = ST_WRITE;
                    n_shift_out = in_wbyte;
                end
                ACT_READ: begin
                    eff_cmd = ST_READ;
                    n_sda   = 1'b1;
                end
                ACT_ACK: begin
                    eff_cmd = ST_ACK;
                    n_sda   = in_ack_bit;
                end
                default: eff_cmd = ST_IDLE;
            endcase
        end

        scl_now = n_scl;
        sda_now = n_sda;

        unique case (eff_cmd)
            ST_START: begin
                if (n_phase == PH_0) begin
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    scl_now = 1'b1;
                    sda_now = 1'b1;
                    n_phase = PH_1;
                end else begin
                    sda_now = 1'b0;
                    n_sda   = 1'b0;
                    n_scl   = 1'b0;
                    finish  = 1'b1;
                end
            end
            ST_WRITE: begin
                unique case (n_phase)
                    PH_0: begin
                        n_sda   = n_shift_out[n_bit_idx];
                        sda_now = n_shift_out[n_bit_idx];
                        n_phase = PH_1;
                    end
                    PH_1: begin
                        scl_now = 1'b1;
                        n_scl   = 1'b0;
                        if (n_bit_idx == BIT_LSB) begin
                            n_phase = PH_2;
                        end else begin
                            n_bit_idx = n_bit_idx - 1'b1;
                            n_phase   = PH_0;
                        end
                    end
                    PH_2: begin
                        n_sda   = 1'b1;
                        sda_now = 1'b1;
                        n_phase = PH_3;
                    end
                    PH_3: begin
                        n_scl   = 1'b1;
                        scl_now = 1'b1;
                        n_phase = PH_4;
                    end
                    default: begin
                        // acknowledge slot sampled while scl is high
                        n_ack_latch = in_sample;
                        n_scl       = 1'b0;
                        finish      = 1'b1;
                    end
                endcase
            end
            ST_READ: begin
                if (n_phase == PH_0) begin
                    n_sda   = 1'b1;
                    sda_now = 1'b1;
                    n_phase = PH_1;
                end else begin
                    n_shift_in[n_bit_idx] = in_sample;
                    scl_now = 1'b1;
                    n_scl   = 1'b0;
                    if (n_bit_idx == BIT_LSB) begin
                        finish = 1'b1;
                    end else begin
                        n_bit_idx = n_bit_idx - 1'b1;
                        n_phase   = PH_0;
                    end
                end
            end
            ST_ACK: begin
                if (n_phase == PH_0) begin
                    n_phase = PH_1;
                end else begin
                    scl_now = 1'b1;
                    n_scl   = 1'b0;
                    finish  = 1'b1;
                end
            end
            ST_STOP: begin
                unique case (n_phase)
                    PH_0: begin
                        n_sda   = 1'b0;
                        n_scl   = 1'b0;
                        scl_now = 1'b0;
                        sda_now = 1'b0;
                        n_phase = PH_1;
                    end
                    PH_1: begin
                        n_scl   = 1'b1;
                        scl_now = 1'b1;
                        n_phase = PH_2;
                    end
                    default: begin
                        n_sda   = 1'b1;
                        sda_now = 1'b1;
                        finish  = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase

        n_cmd = eff_cmd;
        if (finish) begin
            n_cmd     = ST_IDLE;
            n_phase   = PH_0;
            n_bit_idx = BIT_MSB;
        end

        res.scl_level = scl_now;
        res.sda_level = sda_now;
        res.busy_res  = (eff_cmd != ST_IDLE) && !finish;
        res.done_res  = finish;
        res.read_byte = n_shift_in;
        res.ack_seen  = n_ack_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= ST_IDLE;
            r_phase     <= PH_0;
            r_bit_idx   <= BIT_MSB;
            r_shift_out <= '0;
            r_shift_in  <= '0;
            r_ack_latch <= 1'b1;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
        end else if (acc) begin
            r_cmd       <= n_cmd;
            r_phase     <= n_phase;
            r_bit_idx   <= n_bit_idx;
            r_shift_out <= n_shift_out;
            r_shift_in  <= n_shift_in;
            r_ack_latch <= n_ack_latch;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
        end
    end

    // result register with a skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (acc) begin
                if (!r_out_valid || pop) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skd_valid <= 1'b1;
                end
            end else if (pop) begin
                r_out_valid <= r_skd_valid;
                r_skd_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (!r_out_valid || pop) begin
                r_out <= res;
            end else begin
                r_skd <= res;
            end
        end else if (pop && r_skd_valid) begin
            r_out <= r_skd;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_W-RES_W){1'b0}}, r_out};

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid entry held with empty result register");

    a_idle_rewound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd == ST_IDLE) |-> (r_phase == PH_0 && r_bit_idx == BIT_MSB))
        else $error("idle sequencer with phase or bit index not rewound");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_out_valid && !i_m_axis_tready) |=> r_skd_valid)
        else $error("accepted beat lost while result stalled");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> !(res.done_res && res.busy_res))
        else $error("busy and done in the same beat");

    a_done_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && res.done_res) |=> (r_cmd == ST_IDLE))
        else $error("command did not return to idle after done");
`endif

endmodule
